// ===== hw/rtl/tlcs_pkg.sv =====
// Shared types, constants and word-matching helpers for the traffic lamp
// command slave. No dependencies; every other RTL file refers to this package.
`default_nettype none

package tlcs_pkg;

   localparam int unsigned DataWidth   = 16;
   localparam int unsigned WordCount   = 4;
   localparam int unsigned QueueDepth  = 2;
   localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
   localparam int unsigned QueueCountW = $clog2(QueueDepth + 1);

   localparam logic [3:0] ALL_WORDS = 4'b1111;

   // Lamp bit positions inside the three-bit lamp drive.
   localparam int unsigned LAMP_RED_BIT    = 0;
   localparam int unsigned LAMP_YELLOW_BIT = 1;
   localparam int unsigned LAMP_GREEN_BIT  = 2;

   localparam logic [2:0] LAMP_NONE   = 3'b000;
   localparam logic [2:0] LAMP_RED    = 3'b001;
   localparam logic [2:0] LAMP_YELLOW = 3'b010;
   localparam logic [2:0] LAMP_GREEN  = 3'b100;

   // Reset values of the configuration registers.
   localparam logic [DataWidth-1:0] TIMEOUT_RESET      = 16'd8000;
   localparam logic [DataWidth-1:0] BLINK_HALF_RESET   = 16'd400;
   localparam logic [DataWidth-1:0] RED_DELAY_RESET    = 16'd500;
   localparam logic [DataWidth-1:0] YELLOW_DELAY_RESET = 16'd1800;

   typedef enum logic [1:0] {
      CSR_TIMEOUT      = 2'd0,
      CSR_BLINK_HALF   = 2'd1,
      CSR_RED_DELAY    = 2'd2,
      CSR_YELLOW_DELAY = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      WORD_RED    = 2'd0,
      WORD_YELLOW = 2'd1,
      WORD_GREEN  = 2'd2,
      WORD_LONG   = 2'd3
   } word_type;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      logic     is_tick;
      logic     hit;
      word_type word;
   } cmd_type;

   function automatic logic [2:0] word_len(input logic [1:0] w);
      logic [2:0] len;
      case (w)
         WORD_RED:    len = 3'd3;
         WORD_YELLOW: len = 3'd6;
         WORD_GREEN:  len = 3'd5;
         WORD_LONG:   len = 3'd4;
         default:     len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] pos);
      logic [7:0] c;
      case ({w, pos})
         {WORD_RED, 3'd0}:    c = "R";
         {WORD_RED, 3'd1}:    c = "E";
         {WORD_RED, 3'd2}:    c = "D";
         {WORD_YELLOW, 3'd0}: c = "Y";
         {WORD_YELLOW, 3'd1}: c = "E";
         {WORD_YELLOW, 3'd2}: c = "L";
         {WORD_YELLOW, 3'd3}: c = "L";
         {WORD_YELLOW, 3'd4}: c = "O";
         {WORD_YELLOW, 3'd5}: c = "W";
         {WORD_GREEN, 3'd0}:  c = "G";
         {WORD_GREEN, 3'd1}:  c = "R";
         {WORD_GREEN, 3'd2}:  c = "E";
         {WORD_GREEN, 3'd3}:  c = "E";
         {WORD_GREEN, 3'd4}:  c = "N";
         {WORD_LONG, 3'd0}:   c = "L";
         {WORD_LONG, 3'd1}:   c = "O";
         {WORD_LONG, 3'd2}:   c = "N";
         {WORD_LONG, 3'd3}:   c = "G";
         default:             c = 8'h00;
      endcase
      return c;
   endfunction

   // Candidates that still fit after seeing character ch at position pos.
   function automatic logic [3:0] filter_words(input logic [3:0] cands,
                                               input logic [2:0] pos,
                                               input logic [7:0] ch);
      logic [3:0] keep;
      keep = '0;
      for (int w = 0; w < WordCount; w++) begin
         keep[w] = cands[w] && (pos < word_len(w[1:0])) && (word_char(w[1:0], pos) == ch);
      end
      return keep;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/traffic_lamp_command_slave.sv =====
// Traffic lamp command slave: serial command words and millisecond ticks in,
// lamp drive words out. One word per cycle sustained while the queue has room;
// each input passes the matcher, the two-entry queue and the result register.
// The queue lets input continue while a result waits on rsp_stall.
// Synchronous reset clears the matcher, queue, lamps, timers and blinking and
// loads the register defaults (8000, 400, 500, 1800 ticks).
`default_nettype none

module traffic_lamp_command_slave (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [tlcs_pkg::DataWidth-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_kind,
   input  wire logic [7:0]                     req_rx_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_red_on,
   output logic                                rsp_yellow_on,
   output logic                                rsp_green_on,
   output logic                                rsp_ack,
   output logic                                rsp_blinking
);

   logic              queue_full, push, pop, head_valid;
   tlcs_pkg::cmd_type push_cmd, head_cmd;

   tlcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tlcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tlcs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_red_on    (rsp_red_on),
      .rsp_yellow_on (rsp_yellow_on),
      .rsp_green_on  (rsp_green_on),
      .rsp_ack       (rsp_ack),
      .rsp_blinking  (rsp_blinking)
   );

   // Bytes are ignored once blinking has latched.
   a_no_ack_when_blinking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack |-> !rsp_blinking)
      else $error("acknowledge reported while blinking");

   // Blinking drives only the yellow lamp.
   a_blink_yellow_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blinking |-> !rsp_red_on && !rsp_green_on)
      else $error("red or green lamp lit while blinking");

   // A tick never acknowledges a command.
   a_tick_no_ack: assert property (@(posedge clock) disable iff (reset)
      push && push_cmd.is_tick |-> !push_cmd.hit)
      else $error("tick classified as a command word");

endmodule

`default_nettype wire

// ===== hw/rtl/tlcs_front.sv =====
// Front end: accepts input words and runs the command-word matcher.
// Depends on tlcs_pkg for the word tables and the cmd_type struct.
`default_nettype none

module tlcs_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_kind,
   input  wire logic [7:0]      req_rx_byte,
   input  wire logic            queue_full,
   output logic                 req_stall,
   output logic                 push,
   output tlcs_pkg::cmd_type    push_cmd
);

   logic [2:0] pos_ff, pos_in;
   logic [3:0] cand_ff, cand_in;

   logic [3:0] keep_cont, keep_restart, keep;
   logic [2:0] new_pos;
   logic       restart, hit;
   logic [1:0] hit_word;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      keep_cont    = tlcs_pkg::filter_words(cand_ff, pos_ff, req_rx_byte);
      keep_restart = tlcs_pkg::filter_words(tlcs_pkg::ALL_WORDS, 3'd0, req_rx_byte);
      // A character that breaks every candidate is retried as a first letter.
      restart      = (keep_cont == 4'd0);
      keep         = restart ? keep_restart : keep_cont;
      new_pos      = (restart ? 3'd0 : pos_ff) + 3'd1;
      hit          = 1'b0;
      hit_word     = tlcs_pkg::WORD_RED;
      for (int w = 0; w < tlcs_pkg::WordCount; w++) begin
         if (!hit && keep[w] && (tlcs_pkg::word_len(w[1:0]) == new_pos)) begin
            hit      = 1'b1;
            hit_word = w[1:0];
         end
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      cand_in = cand_ff;
      if (push && !req_kind) begin
         if (keep == 4'd0 || hit) begin
            pos_in  = 3'd0;
            cand_in = tlcs_pkg::ALL_WORDS;
         end else begin
            pos_in  = new_pos;
            cand_in = keep;
         end
      end
   end

   always_comb begin
      push_cmd.is_tick = req_kind;
      push_cmd.hit     = !req_kind && hit;
      push_cmd.word    = tlcs_pkg::word_type'(hit_word);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 3'd0;
         cand_ff <= tlcs_pkg::ALL_WORDS;
      end else begin
         pos_ff  <= pos_in;
         cand_ff <= cand_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tlcs_queue.sv =====
// Short register queue that decouples the matcher from the lamp back end.
// Depends on tlcs_pkg for its depth and the cmd_type entry.
`default_nettype none

module tlcs_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tlcs_pkg::cmd_type  push_cmd,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output tlcs_pkg::cmd_type       head_cmd
);

   tlcs_pkg::cmd_type entry_ff [tlcs_pkg::QueueDepth];

   logic [tlcs_pkg::QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tlcs_pkg::QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tlcs_pkg::QueueCountW-1:0] count_ff, count_in;

   localparam logic [tlcs_pkg::QueuePtrW-1:0] LastPtr =
      tlcs_pkg::QueuePtrW'(tlcs_pkg::QueueDepth - 1);

   assign full       = (count_ff == tlcs_pkg::QueueCountW'(tlcs_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tlcs_back.sv =====
// Back end: configuration registers, lamp scheduling, silence timeout and
// blinking, plus the registered result word. Depends on tlcs_pkg.
`default_nettype none

module tlcs_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [tlcs_pkg::DataWidth-1:0] csr_wdata,
   input  wire logic                           head_valid,
   input  wire tlcs_pkg::cmd_type              head_cmd,
   output logic                                pop,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_red_on,
   output logic                                rsp_yellow_on,
   output logic                                rsp_green_on,
   output logic                                rsp_ack,
   output logic                                rsp_blinking
);

   localparam int unsigned W = tlcs_pkg::DataWidth;

   logic [W-1:0] timeout_ff, blink_half_ff, red_delay_ff, yellow_delay_ff;

   logic [2:0]   lamp_ff, lamp_in;
   logic [2:0]   pend_ff, pend_in;
   logic [W-1:0] countdown_ff, countdown_in;
   logic [W-1:0] silence_ff, silence_in;
   logic [W-1:0] blink_cnt_ff, blink_cnt_in;
   logic         blink_ff, blink_in;
   logic         ack_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   rsp_lamp_ff;
   logic         rsp_ack_ff, rsp_blink_ff;

   logic [W-1:0] blink_step, count_step;
   logic [2:0]   sched_lamps;
   logic [W-1:0] sched_delay;

   // The result register frees up when its word is taken, so a new item can
   // be executed in the same cycle.
   assign pop          = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_comb begin
      blink_step  = (blink_cnt_ff != {W{1'b1}}) ? blink_cnt_ff + 1'b1 : blink_cnt_ff;
      count_step  = (countdown_ff != '0) ? countdown_ff - 1'b1 : countdown_ff;
      sched_lamps = tlcs_pkg::LAMP_YELLOW;
      sched_delay = '0;
      case (head_cmd.word)
         tlcs_pkg::WORD_RED: begin
            sched_lamps = tlcs_pkg::LAMP_RED;
            sched_delay = red_delay_ff;
         end
         tlcs_pkg::WORD_YELLOW: begin
            sched_lamps = tlcs_pkg::LAMP_YELLOW;
            sched_delay = yellow_delay_ff;
         end
         tlcs_pkg::WORD_GREEN: begin
            sched_lamps = tlcs_pkg::LAMP_GREEN;
         end
         tlcs_pkg::WORD_LONG: begin
            sched_lamps = tlcs_pkg::LAMP_YELLOW;
         end
         default: begin
            sched_lamps = tlcs_pkg::LAMP_YELLOW;
         end
      endcase
   end

   always_comb begin
      lamp_in      = lamp_ff;
      pend_in      = pend_ff;
      countdown_in = countdown_ff;
      silence_in   = silence_ff;
      blink_cnt_in = blink_cnt_ff;
      blink_in     = blink_ff;
      ack_in       = 1'b0;
      if (pop) begin
         if (blink_ff) begin
            if (head_cmd.is_tick) begin
               if (blink_step >= blink_half_ff) begin
                  lamp_in[tlcs_pkg::LAMP_YELLOW_BIT] = !lamp_ff[tlcs_pkg::LAMP_YELLOW_BIT];
                  blink_cnt_in = '0;
               end else begin
                  blink_cnt_in = blink_step;
               end
            end
         end else if (!head_cmd.is_tick) begin
            silence_in = '0;
            if (head_cmd.hit) begin
               ack_in = 1'b1;
               if (sched_delay == '0) begin
                  lamp_in      = sched_lamps;
                  pend_in      = tlcs_pkg::LAMP_NONE;
                  countdown_in = '0;
               end else begin
                  pend_in      = sched_lamps;
                  countdown_in = sched_delay;
               end
            end
         end else if (pend_ff != tlcs_pkg::LAMP_NONE) begin
            // The silence timer is cleared while a delayed change is pending.
            silence_in   = '0;
            countdown_in = count_step;
            if (count_step == '0) begin
               lamp_in = pend_ff;
               pend_in = tlcs_pkg::LAMP_NONE;
            end
         end else if (silence_ff >= timeout_ff) begin
            blink_in     = 1'b1;
            lamp_in      = tlcs_pkg::LAMP_YELLOW;
            blink_cnt_in = '0;
            pend_in      = tlcs_pkg::LAMP_NONE;
            countdown_in = '0;
         end else begin
            silence_in = silence_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= tlcs_pkg::TIMEOUT_RESET;
         blink_half_ff   <= tlcs_pkg::BLINK_HALF_RESET;
         red_delay_ff    <= tlcs_pkg::RED_DELAY_RESET;
         yellow_delay_ff <= tlcs_pkg::YELLOW_DELAY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tlcs_pkg::CSR_TIMEOUT:      timeout_ff      <= csr_wdata;
            tlcs_pkg::CSR_BLINK_HALF:   blink_half_ff   <= csr_wdata;
            tlcs_pkg::CSR_RED_DELAY:    red_delay_ff    <= csr_wdata;
            tlcs_pkg::CSR_YELLOW_DELAY: yellow_delay_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_ff      <= tlcs_pkg::LAMP_NONE;
         pend_ff      <= tlcs_pkg::LAMP_NONE;
         countdown_ff <= '0;
         silence_ff   <= '0;
         blink_cnt_ff <= '0;
         blink_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lamp_ff      <= lamp_in;
         pend_ff      <= pend_in;
         countdown_ff <= countdown_in;
         silence_ff   <= silence_in;
         blink_cnt_ff <= blink_cnt_in;
         blink_ff     <= blink_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_lamp_ff  <= lamp_in;
         rsp_ack_ff   <= ack_in;
         rsp_blink_ff <= blink_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_on    = rsp_lamp_ff[tlcs_pkg::LAMP_RED_BIT];
   assign rsp_yellow_on = rsp_lamp_ff[tlcs_pkg::LAMP_YELLOW_BIT];
   assign rsp_green_on  = rsp_lamp_ff[tlcs_pkg::LAMP_GREEN_BIT];
   assign rsp_ack       = rsp_ack_ff;
   assign rsp_blinking  = rsp_blink_ff;

endmodule

`default_nettype wire
